// ===== rtl/sorted_min_priority_queue_unit_defines.svh =====
// Assertion macros used by the queue top level
`ifndef SORTED_MIN_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_MIN_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication under reset
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spq assertion failed");
// Next-cycle implication under reset
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");
`else
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

	localparam int DEPTH   = 16;
	localparam int PRIO_W  = 16;
	localparam int PAY_W   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_STAT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [PRIO_W-1:0] priority_req;
		logic [PAY_W-1:0]  payload;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              removed_valid;
		logic [PRIO_W-1:0] removed_priority;
		logic [PAY_W-1:0]  removed_payload;
		logic              head_valid;
		logic [PRIO_W-1:0] head_priority;
		logic [PAY_W-1:0]  head_payload;
		logic [CNT_W-1:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  pay;
	} entry_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t ent;
	} cell_ctl_t;

endpackage

// ===== rtl/spq_if.sv =====
interface spq_req_if;
	logic          valid;
	logic          ready;
	spq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
	logic          valid;
	logic          ready;
	spq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sorted_min_priority_queue_unit.sv =====
// Sorted min-priority queue of spq_pkg::DEPTH entries held in a row of cells, head in
// cell 0. Each request is an enqueue, a dequeue of the head or a status query, and
// yields one response with the status, the removed entry, the new head and the
// occupancy. Equal priorities leave in arrival order. Every cell compares the new
// priority with its own entry and shifts in step with its neighbours, so one request
// completes per cycle; the response register is the only stage, and a new request is
// taken whenever that register is empty or is being drained in the same cycle.
`include "sorted_min_priority_queue_unit_defines.svh"

module sorted_min_priority_queue_unit (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int DEPTH = spq_pkg::DEPTH;
	localparam int CNT_W = spq_pkg::CNT_W;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               out_valid_q;
	spq_pkg::rsp_t      rsp_q;
	spq_pkg::rsp_t      rsp_d;
	spq_pkg::cell_ctl_t ctl;
	logic               accept;
	logic               is_full;
	logic               is_empty;
	logic               enq_ok;
	logic               deq_ok;

	logic               stay  [DEPTH];
	logic               valid [DEPTH];
	spq_pkg::entry_t    ent   [DEPTH];
	spq_pkg::entry_t    ent_d [DEPTH];

	// Take a request when the response register is free or draining
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign enq_ok    = accept && (req.data.opcode == spq_pkg::OP_ENQ) && !is_full;
	assign deq_ok    = accept && (req.data.opcode == spq_pkg::OP_DEQ) && !is_empty;

	// Broadcast the request to the cells
	always_comb begin
		ctl.enq      = enq_ok;
		ctl.deq      = deq_ok;
		ctl.ent.prio = req.data.priority_req;
		ctl.ent.pay  = req.data.payload;
	end

	// Build the cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic            l_stay;
		spq_pkg::entry_t l_ent;
		spq_pkg::entry_t r_ent;

		assign valid[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign l_stay = 1'b1;
			assign l_ent  = '0;
		end else begin : g_mid
			assign l_stay = stay[i-1];
			assign l_ent  = ent[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_ent = '0;
		end else begin : g_inner
			assign r_ent = ent[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.valid     (valid[i]),
			.left_stay (l_stay),
			.left_ent  (l_ent),
			.right_ent (r_ent),
			.stay      (stay[i]),
			.ent       (ent[i]),
			.ent_d     (ent_d[i])
		);
	end

	// Advance the occupancy
	always_comb begin
		count_d = count_q;
		if (enq_ok) begin
			count_d = count_q + 1'b1;
		end else if (deq_ok) begin
			count_d = count_q - 1'b1;
		end
	end

	// Assemble the response from the head after this request
	always_comb begin
		rsp_d = '0;
		case (req.data.opcode)
			spq_pkg::OP_ENQ: begin
				if (is_full) begin
					rsp_d.status = spq_pkg::ST_FULL;
				end
			end
			spq_pkg::OP_DEQ: begin
				if (is_empty) begin
					rsp_d.status = spq_pkg::ST_EMPTY;
				end
			end
			default: begin
				rsp_d.status = spq_pkg::ST_OK;
			end
		endcase
		if (deq_ok) begin
			rsp_d.removed_valid    = 1'b1;
			rsp_d.removed_priority = ent[0].prio;
			rsp_d.removed_payload  = ent[0].pay;
		end
		if (count_d != '0) begin
			rsp_d.head_valid    = 1'b1;
			rsp_d.head_priority = ent_d[0].prio;
			rsp_d.head_payload  = ent_d[0].pay;
		end
		rsp_d.occupancy = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the response until it is taken
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

	`SPQ_ASSERT_NEXT(a_enq_count, clk, arst_n, enq_ok, count_q == $past(count_q) + 1'b1)
	`SPQ_ASSERT_NEXT(a_deq_resp, clk, arst_n, deq_ok, out_valid_q && rsp_q.removed_valid)
	`SPQ_ASSERT_IMPL(a_head_order, clk, arst_n, count_q > CNT_W'(1), ent[0].prio <= ent[1].prio)
	`SPQ_ASSERT_IMPL(a_head_flag, clk, arst_n, out_valid_q, rsp_q.head_valid == (rsp_q.occupancy != '0))

endmodule

// ===== rtl/spq_cell.sv =====
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic               valid,
	input  logic               left_stay,
	input  spq_pkg::entry_t    left_ent,
	input  spq_pkg::entry_t    right_ent,
	output logic               stay,
	output spq_pkg::entry_t    ent,
	output spq_pkg::entry_t    ent_d
);

	spq_pkg::entry_t ent_q;

	// Keep the entry when it goes ahead of the new request
	assign stay = valid && (ent_q.prio <= ctl.ent.prio);

	// Pick the next contents: hold, take new, shift right or shift left
	always_comb begin
		ent_d = ent_q;
		if (ctl.enq) begin
			if (!stay) begin
				if (left_stay) begin
					ent_d = ctl.ent;
				end else begin
					ent_d = left_ent;
				end
			end
		end else if (ctl.deq) begin
			ent_d = right_ent;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign ent = ent_q;

endmodule
